>>> hdl/nefs_pkg.sv
`timescale 1ns / 1ps

package nefs_pkg;

    // nesting depth counter width
    localparam int DEPTH_BITS = 9;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_BEGIN_CHAR     = 2'd0;
    localparam logic [1:0] REG_END_CHAR       = 2'd1;
    localparam logic [1:0] REG_SEPARATOR_CHAR = 2'd2;
    localparam logic [1:0] REG_STRIP_QUOTES   = 2'd3;

    // register reset values
    localparam logic [7:0] BEGIN_CHAR_RST     = 8'd60;
    localparam logic [7:0] END_CHAR_RST       = 8'd62;
    localparam logic [7:0] SEPARATOR_CHAR_RST = 8'd44;

    // fixed bracket, quote, blank and NUL characters
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // input kind codes
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_CHAR    = 1'b1;

    typedef logic signed [DEPTH_BITS-1:0] depth_t;

    localparam depth_t DEPTH_MAX  = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam depth_t DEPTH_MIN  = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam depth_t DEPTH_ZERO = '0;
    localparam depth_t DEPTH_ONE  = depth_t'(1);

    localparam logic [15:0] POS_MAX = 16'hFFFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] character;
    } in_beat_t;

    typedef struct packed {
        logic        append_valid;
        logic [7:0]  append_char;
        logic        field_end;
        logic        entry_done;
        logic [15:0] char_position;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] begin_char;
        logic [7:0] end_char;
        logic [7:0] separator_char;
        logic       strip_quotes;
    } cfg_t;

    typedef struct packed {
        depth_t      nest_depth;
        logic        in_quote;
        logic        finished;
        logic [15:0] position_count;
    } parse_state_t;

endpackage

>>> hdl/nefs_cfg_regs.sv
`timescale 1ns / 1ps

module nefs_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nefs_pkg::PADDR_W-1:0]  paddr,
    input  logic [nefs_pkg::PDATA_W-1:0]  pwdata,
    output logic [nefs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output nefs_pkg::cfg_t                cfg
);

    nefs_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.begin_char     <= nefs_pkg::BEGIN_CHAR_RST;
            cfg_reg.end_char       <= nefs_pkg::END_CHAR_RST;
            cfg_reg.separator_char <= nefs_pkg::SEPARATOR_CHAR_RST;
            cfg_reg.strip_quotes   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                nefs_pkg::REG_BEGIN_CHAR:     cfg_reg.begin_char     <= pwdata[7:0];
                nefs_pkg::REG_END_CHAR:       cfg_reg.end_char       <= pwdata[7:0];
                nefs_pkg::REG_SEPARATOR_CHAR: cfg_reg.separator_char <= pwdata[7:0];
                nefs_pkg::REG_STRIP_QUOTES:   cfg_reg.strip_quotes   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            nefs_pkg::REG_BEGIN_CHAR:     prdata[7:0] = cfg_reg.begin_char;
            nefs_pkg::REG_END_CHAR:       prdata[7:0] = cfg_reg.end_char;
            nefs_pkg::REG_SEPARATOR_CHAR: prdata[7:0] = cfg_reg.separator_char;
            nefs_pkg::REG_STRIP_QUOTES:   prdata[0]   = cfg_reg.strip_quotes;
            default: ;
        endcase
    end

endmodule

>>> hdl/nefs_step.sv
`timescale 1ns / 1ps

module nefs_step (
    input  nefs_pkg::cfg_t         cfg,
    input  nefs_pkg::parse_state_t cur,
    input  nefs_pkg::in_beat_t     in_beat,
    output nefs_pkg::parse_state_t nxt,
    output nefs_pkg::out_beat_t    res
);

    logic [7:0]      c;
    logic            is_opener;
    logic            is_closer;
    logic            is_quote;
    logic            is_blank;
    logic            is_delim;
    logic            quote_new;
    logic            app;
    logic            fend;
    nefs_pkg::depth_t depth_open;
    nefs_pkg::depth_t depth_close;

    function automatic logic depth_open_ok(nefs_pkg::depth_t d);
        return d != nefs_pkg::DEPTH_MAX;
    endfunction

    assign c = in_beat.character;

    // character classes
    assign is_opener = !cur.in_quote &&
                       (c == cfg.begin_char || c == nefs_pkg::CHAR_LT ||
                        c == nefs_pkg::CHAR_LBRACK || c == nefs_pkg::CHAR_LBRACE);
    assign is_quote  = (c == nefs_pkg::CHAR_QUOTE);
    assign quote_new = cur.in_quote ^ is_quote;
    assign is_closer = !quote_new &&
                       (c == cfg.end_char || c == nefs_pkg::CHAR_GT ||
                        c == nefs_pkg::CHAR_RBRACK || c == nefs_pkg::CHAR_RBRACE);
    assign is_blank  = (c == nefs_pkg::CHAR_SPACE) ||
                       (c >= nefs_pkg::CHAR_TAB && c <= nefs_pkg::CHAR_CR);
    assign is_delim  = (c == cfg.separator_char) || (c == cfg.begin_char) ||
                       (c == cfg.end_char);

    // depth after opener, saturating high
    assign depth_open = (is_opener && depth_open_ok(cur.nest_depth)) ?
                        nefs_pkg::depth_t'(cur.nest_depth + nefs_pkg::DEPTH_ONE) :
                        cur.nest_depth;

    // depth after closer, saturating low
    assign depth_close = (is_closer && depth_open != nefs_pkg::DEPTH_MIN) ?
                         nefs_pkg::depth_t'(depth_open - nefs_pkg::DEPTH_ONE) :
                         depth_open;

    // append and field end tests use the new quote flag
    assign app = (!cfg.strip_quotes || depth_open != nefs_pkg::DEPTH_ONE || !is_quote) &&
                 (c != nefs_pkg::CHAR_NUL) &&
                 (quote_new ||
                  ((depth_open > nefs_pkg::DEPTH_ONE || !is_delim) && !is_blank));
    assign fend = !quote_new && depth_open == nefs_pkg::DEPTH_ONE &&
                  (c == cfg.separator_char || c == cfg.end_char);

    // next state and result
    always_comb begin
        nxt = cur;
        res = '0;
        priority if (in_beat.kind == nefs_pkg::KIND_RESTART) begin
            nxt = '0;
        end else if (cur.finished) begin
            nxt = cur;
        end else begin
            nxt.nest_depth     = depth_close;
            nxt.in_quote       = quote_new;
            nxt.finished       = (depth_close == nefs_pkg::DEPTH_ZERO);
            nxt.position_count = (cur.position_count == nefs_pkg::POS_MAX) ?
                                 cur.position_count :
                                 16'(cur.position_count + 16'd1);
            res.append_valid   = app;
            res.append_char    = app ? c : 8'd0;
            res.field_end      = fend;
            res.entry_done     = (depth_close == nefs_pkg::DEPTH_ZERO);
            res.char_position  = cur.position_count;
        end
    end

endmodule

>>> hdl/nested_entry_field_splitter_top.sv
`timescale 1ns / 1ps

// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// input     | s_valid / s_ready         | s_data  (nefs_pkg::in_beat_t)
// result    | m_valid / m_ready         | m_data  (nefs_pkg::out_beat_t)
// config    | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One beat per clock unless the result stalls: the single result register
// behind the parse logic gets a beat's result in the cycle after acceptance.
// s_ready is high while the result register is empty or being drained, so
// input and output overlap without bubbles. Synchronous active-low reset
// clears the parse state, the result valid flag and the registers to their
// defaults. A stalled result holds its register and stalls the input.

module nested_entry_field_splitter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  nefs_pkg::in_beat_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output nefs_pkg::out_beat_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nefs_pkg::PADDR_W-1:0]  paddr,
    input  logic [nefs_pkg::PDATA_W-1:0]  pwdata,
    output logic [nefs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    nefs_pkg::cfg_t         cfg;
    nefs_pkg::parse_state_t state_reg;
    nefs_pkg::parse_state_t state_next;
    nefs_pkg::out_beat_t    res_next;
    nefs_pkg::out_beat_t    m_data_reg;
    logic                   m_valid_reg;
    logic                   s_fire;

    nefs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nefs_step u_step (
        .cfg     (cfg),
        .cur     (state_reg),
        .in_beat (s_data),
        .nxt     (state_next),
        .res     (res_next)
    );

    // accept when the result slot is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // parse state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg <= state_next;
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= res_next;
        end
    end

endmodule
